// File: sv/vct_pkg.sv
// Shared types and codes for the vector clock table.
// Used by vector_clock_table and vct_table; depends on nothing.
package vct_pkg;

  localparam int unsigned ID_W  = 32;
  localparam int unsigned CNT_W = 63;

  typedef enum logic [2:0] {
    ACT_INC    = 3'd0,
    ACT_ADD    = 3'd1,
    ACT_LOOKUP = 3'd2,
    ACT_MERGE  = 3'd3,
    ACT_CMP    = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_PRESENT  = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ORD_EQUAL        = 3'd0,
    ORD_LESS         = 3'd1,
    ORD_GREATER      = 3'd2,
    ORD_CONCURRENT   = 3'd3,
    ORD_INCOMPARABLE = 3'd4
  } order_t;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_RD   = 8'b00000010,
    S_CMP  = 8'b00000100,
    S_ACT  = 8'b00001000,
    S_SHR  = 8'b00010000,
    S_SHW  = 8'b00100000,
    S_INS  = 8'b01000000,
    S_DONE = 8'b10000000
  } state_t;

endpackage

// File: sv/vector_clock_table.sv
// Top level of the vector clock table: sequencer, compare state and result register.
// Depends on vct_pkg and vct_table.
//
// The block holds one vector clock as up to MAX_ENTRIES (node id, counter) pairs
// sorted by ascending signed id, empty after reset. Each input item is one action:
// increment, add node, lookup, merge one received entry, or feed one received
// entry into a running comparison whose order is reported with the entry marked
// last. Items are handled one at a time and in_ready is low while an item is in
// work. The search walks the sorted table through the single read port of the
// entry memory, each entry visited being read in S_RD and compared in S_CMP, up to
// the position p found; an insert then shifts the entries from p upward up by one,
// each move a read in S_SHR and a write in S_SHW, then writes the new entry.
// A compare item reads only the entry at the current compare position. Unknown
// actions and compare entries not marked last give no result item; every other
// item gives exactly one. A finished result sits in the output register until taken.
// The next item may be accepted while it waits; that item's own result is then
// held back until the register is free.
module vector_clock_table #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic signed [31:0] in_node_id,
  input  logic signed [63:0] in_counter,
  input  logic        in_last,
  input  logic        in_no_entry,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [62:0] out_value,
  output logic [2:0]  out_order
);

  // Count and position widths hold the depth itself; addresses only index it.
  localparam int unsigned IW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [IW-1:0] FULL = IW'(MAX_ENTRIES);

  vct_pkg::state_t st_r, st_nxt;

  logic [2:0]        act_r;
  logic signed [31:0] id_r;
  logic [63:0]       cnt_r;
  logic              last_r;
  logic              hit_r;
  logic [IW-1:0]     p_r, k_r, count_r, cpos_r;
  logic              sbig_r, rbig_r, mis_r;

  logic [1:0]        res_status_r;
  logic [62:0]       res_value_r;
  logic [2:0]        res_order_r;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [62:0]       out_value_r;
  logic [2:0]        out_order_r;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic signed [31:0] wid, rid;
  logic [62:0]       wcnt, rcnt;

  // Received counter clamped to zero when negative.
  logic              neg;
  logic [62:0]       cnt63;
  assign neg   = cnt_r[63];
  assign cnt63 = neg ? 63'd0 : cnt_r[62:0];

  vct_table #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wid  (wid),
    .wcnt (wcnt),
    .raddr(raddr),
    .rid  (rid),
    .rcnt (rcnt)
  );

  assign in_ready   = (st_r == vct_pkg::S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;
  assign out_order  = out_order_r;

  // Read address: the search position, or the entry below the shift slot.
  always_comb begin
    raddr = p_r[AW-1:0];
    if (st_r == vct_pkg::S_SHR) begin
      raddr = AW'(k_r - IW'(1));
    end
  end

  // Write port: counter update in place, shift moves, and the new entry.
  always_comb begin
    we    = 1'b0;
    waddr = p_r[AW-1:0];
    wid   = rid;
    wcnt  = rcnt;
    case (st_r)
      vct_pkg::S_ACT: begin
        if (hit_r && act_r == vct_pkg::ACT_INC) begin
          we   = 1'b1;
          wcnt = (rcnt == '1) ? rcnt : rcnt + 63'd1;
        end else if (hit_r && act_r == vct_pkg::ACT_MERGE && cnt63 > rcnt) begin
          we   = 1'b1;
          wcnt = cnt63;
        end
      end
      vct_pkg::S_SHW: begin
        we    = 1'b1;
        waddr = k_r[AW-1:0];
      end
      vct_pkg::S_INS: begin
        we   = 1'b1;
        wid  = id_r;
        wcnt = cnt63;
      end
      default: ;
    endcase
  end

  // Sequencer next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      vct_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_action == vct_pkg::ACT_INC || in_action == vct_pkg::ACT_ADD ||
              in_action == vct_pkg::ACT_LOOKUP) begin
            st_nxt = vct_pkg::S_RD;
          end else if (in_action == vct_pkg::ACT_MERGE || in_action == vct_pkg::ACT_CMP) begin
            st_nxt = in_no_entry ? vct_pkg::S_DONE : vct_pkg::S_RD;
          end
        end
      end
      vct_pkg::S_RD:  st_nxt = (p_r < count_r) ? vct_pkg::S_CMP : vct_pkg::S_ACT;
      vct_pkg::S_CMP: begin
        if (act_r != vct_pkg::ACT_CMP && rid < id_r) begin
          st_nxt = vct_pkg::S_RD;
        end else begin
          st_nxt = vct_pkg::S_ACT;
        end
      end
      vct_pkg::S_ACT: begin
        st_nxt = vct_pkg::S_DONE;
        if (act_r == vct_pkg::ACT_CMP && !last_r) begin
          st_nxt = vct_pkg::S_IDLE;
        end else if (!hit_r && count_r != FULL &&
                     (act_r == vct_pkg::ACT_ADD || act_r == vct_pkg::ACT_MERGE)) begin
          st_nxt = (count_r == p_r) ? vct_pkg::S_INS : vct_pkg::S_SHR;
        end
      end
      vct_pkg::S_SHR: st_nxt = vct_pkg::S_SHW;
      vct_pkg::S_SHW: st_nxt = (k_r - IW'(1) == p_r) ? vct_pkg::S_INS : vct_pkg::S_SHR;
      vct_pkg::S_INS: st_nxt = vct_pkg::S_DONE;
      vct_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          st_nxt = vct_pkg::S_IDLE;
        end
      end
      default: st_nxt = vct_pkg::S_IDLE;
    endcase
  end

  // Compare flags after this entry, used for the order of a last entry.
  logic sbig_nxt, rbig_nxt, mis_nxt;
  always_comb begin
    sbig_nxt = sbig_r;
    rbig_nxt = rbig_r;
    mis_nxt  = mis_r;
    if (!hit_r) begin
      mis_nxt = 1'b1;
    end else if (neg || rcnt > cnt_r[62:0]) begin
      sbig_nxt = 1'b1;
    end else if (rcnt < cnt_r[62:0]) begin
      rbig_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= vct_pkg::S_IDLE;
      count_r     <= '0;
      cpos_r      <= '0;
      sbig_r      <= 1'b0;
      rbig_r      <= 1'b0;
      mis_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      // A result loaded in S_DONE takes the register over in the same cycle.
      if (out_valid_r && out_ready && st_r != vct_pkg::S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        vct_pkg::S_IDLE: begin
          if (in_valid) begin
            act_r        <= in_action;
            id_r         <= in_node_id;
            cnt_r        <= in_counter;
            last_r       <= in_last;
            hit_r        <= 1'b0;
            p_r          <= (in_action == vct_pkg::ACT_CMP) ? cpos_r : '0;
            res_status_r <= vct_pkg::ST_OK;
            res_value_r  <= '0;
            res_order_r  <= vct_pkg::ORD_EQUAL;
            if (in_action == vct_pkg::ACT_CMP && in_no_entry) begin
              // An empty received clock ends any running comparison.
              res_order_r <= (count_r == '0) ? vct_pkg::ORD_EQUAL
                                             : vct_pkg::ORD_INCOMPARABLE;
              cpos_r <= '0;
              sbig_r <= 1'b0;
              rbig_r <= 1'b0;
              mis_r  <= 1'b0;
            end
          end
        end
        vct_pkg::S_CMP: begin
          if (act_r != vct_pkg::ACT_CMP && rid < id_r) begin
            p_r <= p_r + IW'(1);
          end else begin
            hit_r <= (rid == id_r);
          end
        end
        vct_pkg::S_ACT: begin
          k_r <= count_r;
          case (act_r)
            vct_pkg::ACT_INC: begin
              if (!hit_r) res_status_r <= vct_pkg::ST_NOT_FOUND;
            end
            vct_pkg::ACT_LOOKUP: begin
              if (hit_r) res_value_r <= rcnt;
              else res_status_r <= vct_pkg::ST_NOT_FOUND;
            end
            vct_pkg::ACT_ADD: begin
              if (hit_r) res_status_r <= vct_pkg::ST_PRESENT;
              else if (count_r == FULL) res_status_r <= vct_pkg::ST_FULL;
            end
            vct_pkg::ACT_MERGE: begin
              if (!hit_r && count_r == FULL) res_status_r <= vct_pkg::ST_FULL;
            end
            vct_pkg::ACT_CMP: begin
              if (cpos_r != FULL) cpos_r <= cpos_r + IW'(1);
              sbig_r <= sbig_nxt;
              rbig_r <= rbig_nxt;
              mis_r  <= mis_nxt;
              if (last_r) begin
                if (mis_nxt || ({1'b0, p_r} + (IW+1)'(1)) != {1'b0, count_r}) begin
                  res_order_r <= vct_pkg::ORD_INCOMPARABLE;
                end else if (sbig_nxt && rbig_nxt) begin
                  res_order_r <= vct_pkg::ORD_CONCURRENT;
                end else if (sbig_nxt) begin
                  res_order_r <= vct_pkg::ORD_GREATER;
                end else if (rbig_nxt) begin
                  res_order_r <= vct_pkg::ORD_LESS;
                end else begin
                  res_order_r <= vct_pkg::ORD_EQUAL;
                end
                cpos_r <= '0;
                sbig_r <= 1'b0;
                rbig_r <= 1'b0;
                mis_r  <= 1'b0;
              end
            end
            default: ;
          endcase
        end
        vct_pkg::S_SHW: begin
          k_r <= k_r - IW'(1);
        end
        vct_pkg::S_INS: begin
          count_r <= count_r + IW'(1);
        end
        vct_pkg::S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_value_r  <= res_value_r;
            out_order_r  <= res_order_r;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: sv/vct_table.sv
// Entry storage of the vector clock table: one write port, one registered read port.
// Depends on vct_pkg for the field widths.
module vct_table #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [AW-1:0]                       waddr,
  input  logic signed [vct_pkg::ID_W-1:0]     wid,
  input  logic [vct_pkg::CNT_W-1:0]           wcnt,
  input  logic [AW-1:0]                       raddr,
  output logic signed [vct_pkg::ID_W-1:0]     rid,
  output logic [vct_pkg::CNT_W-1:0]           rcnt
);

  logic [vct_pkg::ID_W-1:0]  ids_mem [DEPTH];
  logic [vct_pkg::CNT_W-1:0] cnt_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      ids_mem[waddr] <= wid;
      cnt_mem[waddr] <= wcnt;
    end
    rid  <= ids_mem[raddr];
    rcnt <= cnt_mem[raddr];
  end

endmodule
